### rtl/qgt_pkg.sv
// Shared types and constants for the quantized GEMM tile.
`timescale 1ns / 1ps
`default_nettype none

package qgt_pkg;

  // Default tile shape
  localparam int TILE_ROWS_DEF = 6;
  localparam int TILE_COLS_DEF = 4;

  // Bytes carried per word for A and B
  localparam int A_BYTES = 6;
  localparam int B_BYTES = 4;

  localparam int ACC_W      = 32;
  localparam int CFG_ADDR_W = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_A_ZERO   = 3'd0;
  localparam logic [2:0] REG_B_ZERO   = 3'd1;
  localparam logic [2:0] REG_MULT     = 3'd2;
  localparam logic [2:0] REG_SHIFT    = 3'd3;
  localparam logic [2:0] REG_OUT_ZERO = 3'd4;
  localparam logic [2:0] REG_CLAMP_LO = 3'd5;
  localparam logic [2:0] REG_CLAMP_HI = 3'd6;

  localparam logic [30:0] MULT_RESET     = 31'h4000_0000;
  localparam logic [7:0]  CLAMP_HI_RESET = 8'hFF;

  // Operation codes
  localparam logic OP_BIAS = 1'b0;
  localparam logic OP_ACC  = 1'b1;

  typedef struct packed {
    logic [7:0]  a_zero;
    logic [7:0]  b_zero;
    logic [30:0] mult;
    logic [4:0]  shift;
    logic [7:0]  out_zero;
    logic [7:0]  clamp_lo;
    logic [7:0]  clamp_hi;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [47:0] a_column;
    logic [31:0] b_row;
    logic [1:0]  bias_column;
    logic [31:0] bias_value;
    logic [2:0]  rows_valid;
    logic [2:0]  cols_valid;
    logic        last;
  } item_t;

  // Tags that travel with each result element
  typedef struct packed {
    logic [2:0] row;
    logic [1:0] col;
    logic       fin;
  } meta_t;

endpackage

`default_nettype wire

### rtl/qgt_cfg_regs.sv
// APB register file holding the zero points, requant settings and clamps.
`timescale 1ns / 1ps
`default_nettype none

module qgt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qgt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output qgt_pkg::cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_zero   <= '0;
      cfg.b_zero   <= '0;
      cfg.mult     <= qgt_pkg::MULT_RESET;
      cfg.shift    <= '0;
      cfg.out_zero <= '0;
      cfg.clamp_lo <= '0;
      cfg.clamp_hi <= qgt_pkg::CLAMP_HI_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        qgt_pkg::REG_A_ZERO:   cfg.a_zero   <= pwdata[7:0];
        qgt_pkg::REG_B_ZERO:   cfg.b_zero   <= pwdata[7:0];
        qgt_pkg::REG_MULT:     cfg.mult     <= pwdata[30:0];
        qgt_pkg::REG_SHIFT:    cfg.shift    <= pwdata[4:0];
        qgt_pkg::REG_OUT_ZERO: cfg.out_zero <= pwdata[7:0];
        qgt_pkg::REG_CLAMP_LO: cfg.clamp_lo <= pwdata[7:0];
        qgt_pkg::REG_CLAMP_HI: cfg.clamp_hi <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      qgt_pkg::REG_A_ZERO:   prdata = {24'd0, cfg.a_zero};
      qgt_pkg::REG_B_ZERO:   prdata = {24'd0, cfg.b_zero};
      qgt_pkg::REG_MULT:     prdata = {1'b0, cfg.mult};
      qgt_pkg::REG_SHIFT:    prdata = {27'd0, cfg.shift};
      qgt_pkg::REG_OUT_ZERO: prdata = {24'd0, cfg.out_zero};
      qgt_pkg::REG_CLAMP_LO: prdata = {24'd0, cfg.clamp_lo};
      qgt_pkg::REG_CLAMP_HI: prdata = {24'd0, cfg.clamp_hi};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/qgt_mac_array.sv
// Grid of multiply-accumulate cells with bias load and clear on tile end.
`timescale 1ns / 1ps
`default_nettype none

module qgt_mac_array #(
  parameter int TILE_ROWS = qgt_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = qgt_pkg::TILE_COLS_DEF,
  parameter int ACC_N     = TILE_ROWS * TILE_COLS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   apply,
  input  qgt_pkg::item_t                         item,
  input  logic [7:0]                             a_zero,
  input  logic [7:0]                             b_zero,
  output logic [ACC_N-1:0][qgt_pkg::ACC_W-1:0]   acc_new
);

  logic signed [8:0]         a_diff [TILE_ROWS];
  logic signed [8:0]         b_diff [TILE_COLS];
  logic [qgt_pkg::ACC_W-1:0] acc    [ACC_N];

  // Offset-corrected A bytes; rows past the carried bytes see a zero byte
  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_a
    logic [7:0] a_byte;
    if (r < qgt_pkg::A_BYTES) begin : g_byte
      assign a_byte = item.a_column[8*r +: 8];
    end else begin : g_zero
      assign a_byte = 8'd0;
    end
    assign a_diff[r] = $signed({1'b0, a_byte}) - $signed({1'b0, a_zero});
  end

  // Offset-corrected B bytes
  for (genvar j = 0; j < TILE_COLS; j++) begin : g_b
    logic [7:0] b_byte;
    if (j < qgt_pkg::B_BYTES) begin : g_byte
      assign b_byte = item.b_row[8*j +: 8];
    end else begin : g_zero
      assign b_byte = 8'd0;
    end
    assign b_diff[j] = $signed({1'b0, b_byte}) - $signed({1'b0, b_zero});
  end

  // One MAC cell per accumulator
  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    for (genvar j = 0; j < TILE_COLS; j++) begin : g_col
      localparam int IDX = r * TILE_COLS + j;
      logic signed [17:0] prod;
      logic               bias_hit;

      assign prod     = a_diff[r] * b_diff[j];
      assign bias_hit = (32'(item.bias_column) == j);

      assign acc_new[IDX] = (item.op == qgt_pkg::OP_BIAS) ?
                            (bias_hit ? item.bias_value : acc[IDX]) :
                            (acc[IDX] + 32'(prod));

      always_ff @(posedge clk) begin
        if (rst) begin
          acc[IDX] <= '0;
        end else if (apply) begin
          acc[IDX] <= item.last ? '0 : acc_new[IDX];
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/qgt_drain.sv
// Tile snapshot and row-major issue of the valid elements to requantization.
`timescale 1ns / 1ps
`default_nettype none

module qgt_drain #(
  parameter int TILE_ROWS = qgt_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = qgt_pkg::TILE_COLS_DEF,
  parameter int ACC_N     = TILE_ROWS * TILE_COLS,
  parameter int IDX_W     = (ACC_N > 1) ? $clog2(ACC_N) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [2:0]                           rows_valid,
  input  logic [2:0]                           cols_valid,
  input  logic [ACC_N-1:0][qgt_pkg::ACC_W-1:0] acc_new,
  input  logic                                 advance,
  output logic                                 busy,
  output logic                                 s1_valid,
  output logic [qgt_pkg::ACC_W-1:0]            s1_value,
  output qgt_pkg::meta_t                       s1_meta
);

  logic [qgt_pkg::ACC_W-1:0] snap [ACC_N];
  logic                      issuing;
  logic [2:0]                r_cnt;
  logic [2:0]                c_cnt;
  logic [2:0]                rows_n;
  logic [2:0]                cols_n;
  logic [2:0]                rows_clip;
  logic [2:0]                cols_clip;
  logic [IDX_W-1:0]          idx;
  logic                      row_end;
  logic                      col_end;

  assign busy = issuing;

  // Counts above the tile size fall back to the tile size
  assign rows_clip = (32'(rows_valid) > TILE_ROWS) ? 3'(TILE_ROWS) : rows_valid;
  assign cols_clip = (32'(cols_valid) > TILE_COLS) ? 3'(TILE_COLS) : cols_valid;

  assign idx     = IDX_W'(int'(r_cnt) * TILE_COLS + int'(c_cnt));
  assign col_end = (c_cnt == 3'(cols_n - 3'd1));
  assign row_end = (r_cnt == 3'(rows_n - 3'd1));

  // Snapshot of the finished tile; the grid is free for the next tile
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < ACC_N; i++) begin
        snap[i] <= acc_new[i];
      end
    end
  end

  // Issue sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      r_cnt   <= '0;
      c_cnt   <= '0;
      rows_n  <= '0;
      cols_n  <= '0;
    end else if (start) begin
      issuing <= (rows_clip != 3'd0) && (cols_clip != 3'd0);
      r_cnt   <= '0;
      c_cnt   <= '0;
      rows_n  <= rows_clip;
      cols_n  <= cols_clip;
    end else if (issuing && advance) begin
      if (col_end) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + 3'd1;
        if (row_end) begin
          issuing <= 1'b0;
        end
      end else begin
        c_cnt <= c_cnt + 3'd1;
      end
    end
  end

  // Read stage feeding the requant pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && issuing) begin
      s1_value     <= snap[idx];
      s1_meta.row  <= r_cnt;
      s1_meta.col  <= c_cnt[1:0];
      s1_meta.fin  <= row_end && col_end;
    end
  end

endmodule

`default_nettype wire

### rtl/qgt_requant.sv
// Requantization pipeline: Q31 high multiply, rounding shift, saturation, clamp.
`timescale 1ns / 1ps
`default_nettype none

module qgt_requant (
  input  logic                      clk,
  input  logic                      rst,
  input  qgt_pkg::cfg_t             cfg,
  output logic                      advance,
  input  logic                      in_valid,
  input  logic [qgt_pkg::ACC_W-1:0] in_value,
  input  qgt_pkg::meta_t            in_meta,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_value,
  output qgt_pkg::meta_t            out_meta
);

  logic               p_valid;
  logic signed [63:0] p_prod;
  qgt_pkg::meta_t     p_meta;

  logic               y_valid;
  logic signed [31:0] y_val;
  qgt_pkg::meta_t     y_meta;

  logic signed [64:0] rnd;
  logic signed [32:0] hi;
  logic signed [31:0] y_sat;
  logic signed [31:0] y_fix;

  logic signed [33:0] half;
  logic signed [33:0] shifted;
  logic signed [15:0] s16;
  logic signed [16:0] zsum;
  logic signed [15:0] z16;
  logic [7:0]         u8;
  logic [7:0]         lo_c;
  logic [7:0]         res;

  // Whole pipeline moves when the output word is free or taken
  assign advance = !out_valid || out_ready;

  // Doubling high multiply with rounding, saturation and negative fixup
  always_comb begin
    rnd = $signed({p_prod, 1'b0}) + 65'sd2147483648;
    hi  = rnd[64:32];
    if (hi[32] != hi[31]) begin
      y_sat = hi[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      y_sat = hi[31:0];
    end
    if ((cfg.shift != 5'd0) && y_sat[31]) begin
      y_fix = y_sat - 32'sd1;
    end else begin
      y_fix = y_sat;
    end
  end

  // Rounding right shift, int16 saturation, zero point, uint8 and clamp
  always_comb begin
    half = 34'sd1 <<< (cfg.shift - 5'd1);
    if (cfg.shift != 5'd0) begin
      shifted = (34'(y_val) + half) >>> cfg.shift;
    end else begin
      shifted = 34'(y_val);
    end

    if (shifted > 34'sd32767) begin
      s16 = 16'sh7FFF;
    end else if (shifted < -34'sd32768) begin
      s16 = 16'sh8000;
    end else begin
      s16 = shifted[15:0];
    end

    zsum = 17'(s16) + $signed({9'd0, cfg.out_zero});
    if (zsum > 17'sd32767) begin
      z16 = 16'sh7FFF;
    end else if (zsum < -17'sd32768) begin
      z16 = 16'sh8000;
    end else begin
      z16 = zsum[15:0];
    end

    if (z16 < 16'sd0) begin
      u8 = 8'd0;
    end else if (z16 > 16'sd255) begin
      u8 = 8'd255;
    end else begin
      u8 = z16[7:0];
    end

    lo_c = (u8 < cfg.clamp_lo) ? cfg.clamp_lo : u8;
    res  = (lo_c > cfg.clamp_hi) ? cfg.clamp_hi : lo_c;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      y_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      p_valid   <= in_valid;
      y_valid   <= p_valid;
      out_valid <= y_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      p_prod    <= $signed(in_value) * $signed({1'b0, cfg.mult});
      p_meta    <= in_meta;
      y_val     <= y_fix;
      y_meta    <= p_meta;
      out_value <= res;
      out_meta  <= y_meta;
    end
  end

endmodule

`default_nettype wire

### rtl/quantized_gemm_tile_6x4.sv
// Quantized GEMM tile: one k step or bias load per cycle while the input is not
// held; the tile end drains requantized elements at one per cycle while the output
// is not stalled. The first result of a tile passes the snapshot, the drain read
// stage and the requant product, rounding and output registers; a tile's last word
// waits while the previous tile is still being read out of the snapshot. Synchronous
// reset clears the accumulators and the pipeline and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module quantized_gemm_tile_6x4 #(
  parameter int TILE_ROWS = qgt_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = qgt_pkg::TILE_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qgt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // a_column[47:0], b_row[79:48], bias_column[81:80], bias_value[113:82],
  // rows_valid[116:114], cols_valid[119:117]
  input  logic [119:0]                   s_tdata,
  // op[0]
  input  logic [0:0]                     s_tuser,
  input  logic                           s_tlast,
  // Output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // row_index[2:0], col_index[4:3], out_value[12:5], zero pad[15:13]
  output logic [15:0]                    m_tdata,
  output logic                           m_tlast
);

  localparam int ACC_N = TILE_ROWS * TILE_COLS;
  localparam int IDX_W = (ACC_N > 1) ? $clog2(ACC_N) : 1;

  qgt_pkg::cfg_t                        cfg;
  qgt_pkg::item_t                       in_item;
  logic                                 in_v;
  logic                                 apply;
  logic                                 start;
  logic                                 busy;
  logic                                 advance;
  logic [ACC_N-1:0][qgt_pkg::ACC_W-1:0] acc_new;
  logic                                 s1_valid;
  logic [qgt_pkg::ACC_W-1:0]            s1_value;
  qgt_pkg::meta_t                       s1_meta;
  logic [7:0]                           out_value;
  qgt_pkg::meta_t                       out_meta;

  qgt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A tile end waits in the input register while the snapshot is in use
  assign apply    = in_v && !(in_item.last && busy);
  assign s_tready = !in_v || apply;
  assign start    = apply && in_item.last;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op          <= s_tuser[0];
      in_item.a_column    <= s_tdata[47:0];
      in_item.b_row       <= s_tdata[79:48];
      in_item.bias_column <= s_tdata[81:80];
      in_item.bias_value  <= s_tdata[113:82];
      in_item.rows_valid  <= s_tdata[116:114];
      in_item.cols_valid  <= s_tdata[119:117];
      in_item.last        <= s_tlast;
    end
  end

  qgt_mac_array #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .ACC_N     (ACC_N)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .apply   (apply),
    .item    (in_item),
    .a_zero  (cfg.a_zero),
    .b_zero  (cfg.b_zero),
    .acc_new (acc_new)
  );

  qgt_drain #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .ACC_N     (ACC_N),
    .IDX_W     (IDX_W)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .rows_valid (in_item.rows_valid),
    .cols_valid (in_item.cols_valid),
    .acc_new    (acc_new),
    .advance    (advance),
    .busy       (busy),
    .s1_valid   (s1_valid),
    .s1_value   (s1_value),
    .s1_meta    (s1_meta)
  );

  qgt_requant u_requant (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .in_valid  (s1_valid),
    .in_value  (s1_value),
    .in_meta   (s1_meta),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_meta  (out_meta)
  );

  // Output word packing
  assign m_tdata = {3'd0, out_value, out_meta.col, out_meta.row};
  assign m_tlast = out_meta.fin;

endmodule

`default_nettype wire

### verif/quantized_gemm_tile_6x4_tb.sv
// Self-checking testbench for the 6x4 quantized GEMM tile: directed and random tiles.
`timescale 1ns / 1ps

module quantized_gemm_tile_6x4_tb;

  localparam int NROW          = qgt_pkg::TILE_ROWS_DEF;
  localparam int NCOL          = qgt_pkg::TILE_COLS_DEF;
  localparam int STALL_LIMIT   = 5000;
  // margin for the first element after the last word, then up to 24 drained elements
  localparam int SETTLE_CYCLES = 40;
  localparam longint I32_MIN   = -(longint'(1) <<< 31);
  localparam longint I32_MAX   = (longint'(1) <<< 31) - 1;

  // One requantized output element as it leaves the block
  typedef struct packed {
    logic [2:0] row;
    logic [1:0] col;
    logic [7:0] value;
    logic       fin;
  } tile_elem_t;

  // Tracks register settings and accumulators, and holds the elements still due
  class tile_scoreboard;
    qgt_pkg::cfg_t cfg;
    logic [31:0]   acc [NROW*NCOL];
    tile_elem_t    pending [$];
    int            errors;

    function new();
      cfg          = '0;
      cfg.mult     = qgt_pkg::MULT_RESET;
      cfg.clamp_hi = qgt_pkg::CLAMP_HI_RESET;
      foreach (acc[i]) acc[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        qgt_pkg::REG_A_ZERO:   cfg.a_zero   = value[7:0];
        qgt_pkg::REG_B_ZERO:   cfg.b_zero   = value[7:0];
        qgt_pkg::REG_MULT:     cfg.mult     = value[30:0];
        qgt_pkg::REG_SHIFT:    cfg.shift    = value[4:0];
        qgt_pkg::REG_OUT_ZERO: cfg.out_zero = value[7:0];
        qgt_pkg::REG_CLAMP_LO: cfg.clamp_lo = value[7:0];
        qgt_pkg::REG_CLAMP_HI: cfg.clamp_hi = value[7:0];
        default: ;
      endcase
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Q31 high multiply, rounding shift, zero point, saturations and clamp
    function logic [7:0] requantize(logic [31:0] raw);
      longint x, y;
      x = longint'(signed'(raw));
      y = (2 * x * longint'(cfg.mult) + (longint'(1) <<< 31)) >>> 32;
      y = clip(y, I32_MIN, I32_MAX);
      if (cfg.shift != 0 && y < 0) y = longint'(int'(y - 1));
      if (cfg.shift != 0) y = (y + (longint'(1) <<< (cfg.shift - 1))) >>> cfg.shift;
      y = clip(y, -32768, 32767);
      y = clip(y + longint'(cfg.out_zero), -32768, 32767);
      y = clip(y, 0, 255);
      if (y < longint'(cfg.clamp_lo)) y = longint'(cfg.clamp_lo);
      if (y > longint'(cfg.clamp_hi)) y = longint'(cfg.clamp_hi);
      return y[7:0];
    endfunction

    // Apply one accepted input word; a tile end queues the valid elements
    function void note_word(qgt_pkg::item_t w);
      int          a, b;
      int unsigned rows, cols, n, total;
      tile_elem_t  e;
      if (w.op == qgt_pkg::OP_BIAS) begin
        if (w.bias_column < NCOL)
          for (int r = 0; r < NROW; r++) acc[r*NCOL + w.bias_column] = w.bias_value;
      end else begin
        for (int r = 0; r < NROW; r++) begin
          a = int'(w.a_column[8*r +: 8]) - int'(cfg.a_zero);
          for (int j = 0; j < NCOL; j++) begin
            b = int'(w.b_row[8*j +: 8]) - int'(cfg.b_zero);
            acc[r*NCOL + j] += a * b;
          end
        end
      end
      if (!w.last) return;
      rows  = (w.rows_valid > NROW) ? NROW : w.rows_valid;
      cols  = (w.cols_valid > NCOL) ? NCOL : w.cols_valid;
      total = rows * cols;
      n     = 0;
      for (int r = 0; r < rows; r++) begin
        for (int j = 0; j < cols; j++) begin
          e.row   = 3'(r);
          e.col   = 2'(j);
          e.value = requantize(acc[r*NCOL + j]);
          e.fin   = (n + 1 == total);
          pending.push_back(e);
          n++;
        end
      end
      foreach (acc[i]) acc[i] = '0;
    endfunction

    function void check_result(logic [2:0] row, logic [1:0] col, logic [7:0] value,
                               logic fin);
      tile_elem_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected element row %0d col %0d value %0d last %0b",
                 $time, row, col, value, fin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if ({row, col, value, fin} !== e) begin
        $display("%0t: mismatch expected row %0d col %0d value %0d last %0b,",
                 $time, e.row, e.col, e.value, e.fin);
        $display("    got row %0d col %0d value %0d last %0b", row, col, value, fin);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         psel, penable, pwrite;
  logic [qgt_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid, s_tready;
  logic [119:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         s_tlast;
  logic         m_tvalid, m_tready;
  logic [15:0]  m_tdata;
  logic         m_tlast;

  int             send_idle_pct;
  int             recv_idle_pct;
  int             quiet_cycles;
  tile_scoreboard sb;

  quantized_gemm_tile_6x4 u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Output side: check each accepted word, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata[2:0], m_tdata[4:3], m_tdata[12:5], m_tlast);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: any handshake on either stream or the register port is progress
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic program_requant(input logic [7:0] a_zero, input logic [7:0] b_zero,
                                 input logic [30:0] mult, input logic [4:0] shift,
                                 input logic [7:0] out_zero, input logic [7:0] lo,
                                 input logic [7:0] hi);
    write_reg(qgt_pkg::REG_A_ZERO, {24'd0, a_zero});
    write_reg(qgt_pkg::REG_B_ZERO, {24'd0, b_zero});
    write_reg(qgt_pkg::REG_MULT, {1'b0, mult});
    write_reg(qgt_pkg::REG_SHIFT, {27'd0, shift});
    write_reg(qgt_pkg::REG_OUT_ZERO, {24'd0, out_zero});
    write_reg(qgt_pkg::REG_CLAMP_LO, {24'd0, lo});
    write_reg(qgt_pkg::REG_CLAMP_HI, {24'd0, hi});
  endtask

  // Input side: random gap, then hold the word until it is taken
  task automatic send_word(input qgt_pkg::item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.cols_valid, w.rows_valid, w.bias_value, w.bias_column, w.b_row,
                 w.a_column};
    s_tuser  <= w.op;
    s_tlast  <= w.last;
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
  endtask

  // Wait for every due element, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic qgt_pkg::item_t make_word(logic op, logic [47:0] a, logic [31:0] b,
                                               logic [1:0] bc, logic [31:0] bv,
                                               logic [2:0] rows, logic [2:0] cols,
                                               logic last_flag);
    qgt_pkg::item_t w;
    w.op          = op;
    w.a_column    = a;
    w.b_row       = b;
    w.bias_column = bc;
    w.bias_value  = bv;
    w.rows_valid  = rows;
    w.cols_valid  = cols;
    w.last        = last_flag;
    return w;
  endfunction

  function automatic qgt_pkg::item_t rand_word(logic op, logic last_flag);
    qgt_pkg::item_t w;
    w.op          = op;
    w.a_column    = {16'($urandom), 32'($urandom)};
    w.b_row       = $urandom;
    w.bias_column = 2'($urandom_range(0, 3));
    w.bias_value  = $urandom_range(0, 1) ? 32'($urandom)
                                         : 32'($urandom_range(0, 4000)) - 32'd2000;
    // tile ends mostly carry a sane shape; larger counts are clipped to the tile size
    if (last_flag && $urandom_range(0, 99) < 85) begin
      w.rows_valid = 3'($urandom_range(1, NROW));
      w.cols_valid = 3'($urandom_range(1, NCOL));
    end else begin
      w.rows_valid = 3'($urandom_range(0, 7));
      w.cols_valid = 3'($urandom_range(0, 7));
    end
    w.last = last_flag;
    return w;
  endfunction

  // One random tile: mostly k steps with some bias loads mixed in
  task automatic run_tile(output int sent);
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++)
      send_word(rand_word(($urandom_range(0, 3) == 0) ? qgt_pkg::OP_BIAS : qgt_pkg::OP_ACC,
                          k == len - 1));
    sent = len;
  endtask

  task automatic random_setup();
    logic [7:0] lo, hi;
    if ($urandom_range(0, 4) != 0) begin
      lo = 8'($urandom_range(0, 60));
      hi = 8'($urandom_range(195, 255));
    end else begin
      lo = 8'($urandom);
      hi = 8'($urandom);
    end
    program_requant(8'($urandom), 8'($urandom), 31'($urandom), 5'($urandom),
                    8'($urandom), lo, hi);
  endtask

  initial begin
    int sent, n;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 62;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extreme biases, wrap, oversize and empty tile shapes
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd0, 32'h7FFF_FFFF, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd1, 32'h8000_0000, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd2, 32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd3, 32'd300, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_ACC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd0, '0,
                        3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_ACC, '0, '0, 2'd0, '0, 3'd6, 3'd4, 1'b1));
    send_word(make_word(qgt_pkg::OP_ACC, 48'h0102_0304_0506, 32'h0A0B_0C0D, 2'd0, '0,
                        3'd7, 3'd7, 1'b1));
    // tile ending on a bias load
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd2, 32'd12345, 3'd3, 3'd2, 1'b1));
    // zero rows, then zero columns: nothing emitted, accumulators still clear
    send_word(make_word(qgt_pkg::OP_ACC, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 2'd0, '0,
                        3'd0, 3'd4, 1'b1));
    send_word(make_word(qgt_pkg::OP_ACC, 48'h5555_5555_5555, 32'hAAAA_AAAA, 2'd0, '0,
                        3'd6, 3'd0, 1'b1));
    send_word(make_word(qgt_pkg::OP_ACC, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 2'd0, '0,
                        3'd1, 3'd1, 1'b1));
    send_word(make_word(qgt_pkg::OP_ACC, 48'h5555_5555_5555, 32'hAAAA_AAAA, 2'd0, '0,
                        3'd5, 3'd3, 1'b1));
    settle();

    // Largest settings everywhere
    program_requant(8'd255, 8'd255, 31'h7FFF_FFFF, 5'd31, 8'd255, 8'd0, 8'd255);
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd0, 32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd1, 32'h8000_0000, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_ACC, '0, '0, 2'd0, '0, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_ACC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd0, '0,
                        3'd6, 3'd4, 1'b1));
    settle();

    // Zero multiplier and crossed clamp bounds
    program_requant(8'd0, 8'd0, 31'd0, 5'd0, 8'd0, 8'd200, 8'd50);
    send_word(make_word(qgt_pkg::OP_BIAS, '0, '0, 2'd3, 32'h7FFF_FFFF, 3'd0, 3'd0, 1'b0));
    send_word(make_word(qgt_pkg::OP_ACC, 48'h1234_5678_9ABC, 32'hDEAD_BEEF, 2'd0, '0,
                        3'd2, 3'd4, 1'b1));

    // Random tiles under changing settings and idle patterns
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      if (seg == 2) begin
        send_idle_pct = 62;
        recv_idle_pct = 23;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setup();
      sent = 0;
      while (sent < 25) begin
        run_tile(n);
        sent += n;
      end
    end
    settle();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/qgt_pkg.sv
rtl/qgt_cfg_regs.sv
rtl/qgt_mac_array.sv
rtl/qgt_drain.sv
rtl/qgt_requant.sv
rtl/quantized_gemm_tile_6x4.sv
verif/quantized_gemm_tile_6x4_tb.sv
